/* hw/rtl/stco_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stco_pkg
// Shared sizes, codes and types of the sample-to-chunk offset mapper.
// ----------------------------------------------------------------------------
package stco_pkg;

  localparam int MAX_RULES  = 256;
  localparam int MAX_CHUNKS = 4096;

  // table address widths and widths of counts that can reach the table depth
  localparam int RULE_AW  = $clog2(MAX_RULES);
  localparam int CHUNK_AW = $clog2(MAX_CHUNKS);
  localparam int RULE_CW  = $clog2(MAX_RULES + 1);
  localparam int CHUNK_CW = $clog2(MAX_CHUNKS + 1);

  // register map
  localparam logic REG_RULE_COUNT  = 1'b0;
  localparam logic REG_CHUNK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD_RULE  = 2'd0,
    ACT_LOAD_CHUNK = 2'd1,
    ACT_RESTART    = 2'd2,
    ACT_MAP_SAMPLE = 2'd3
  } action_t;

  localparam logic STATUS_MAPPED   = 1'b0;
  localparam logic STATUS_PAST_END = 1'b1;

  // register values as the mapper sees them, plus write strobes
  typedef struct packed {
    logic [RULE_CW-1:0]  rules_used;
    logic [CHUNK_CW-1:0] chunks_used;
    logic                rule_wr;
    logic                chunk_wr;
  } cfg_t;

  // one result word with its load strobe
  typedef struct packed {
    logic        load;
    logic [63:0] sample_offset;
    logic [31:0] sample_number;
    logic [11:0] chunk_number;
    logic        status;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/sample_to_chunk_offset_mapper_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sample_to_chunk_offset_mapper_unit
// Maps a stream of sample sizes to file byte offsets through a chunk table.
//
// Input channel (in_valid/in_stall) carries one word per action: load rule,
// load chunk offset, restart, or map one sample. Loads and restart give no
// result. A map gives exactly one result word on the
// output channel (out_valid/out_stall).
// Within an open chunk a map is accepted, then its result goes into the output
// register. Opening a new chunk adds a search start and a chunk offset memory
// read, a scan step per candidate chunk, with a rule memory read each while
// rules lie ahead of the rule pointer, and a rule memory read per rule the
// pointer advances over. The rule pointer is kept between chunks and
// dropped on a rule load, a register write, a restart or running past the
// last chunk; a full rescan reads up to rule_count rules, and an empty rule
// table is scanned one chunk per step.
// rule_count and chunk_count are written over APB at 0x0 and 0x4.
// Reset clears registers and mapping state; the tables keep their contents
// and must be loaded before use. No clearing pass is run.
// If the receiver stalls, the result is held and the next item is accepted;
// a further map waits for the output register.
// ----------------------------------------------------------------------------
module sample_to_chunk_offset_mapper_unit
  import stco_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [11:0] table_index,
  input  wire logic [31:0] start_chunk,
  input  wire logic [31:0] chunk_sample_count,
  input  wire logic [63:0] chunk_offset,
  input  wire logic [31:0] size_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] sample_offset,
  output logic      [31:0] sample_number,
  output logic      [11:0] chunk_number,
  output logic             status
);

  cfg_t cfg;
  res_t res;
  logic out_free;

  stco_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stco_map_ctrl u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .table_index        (table_index),
    .start_chunk        (start_chunk),
    .chunk_sample_count (chunk_sample_count),
    .chunk_offset       (chunk_offset),
    .size_bytes         (size_bytes),
    .cfg                (cfg),
    .out_free           (out_free),
    .res                (res)
  );

  stco_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_offset (sample_offset),
    .sample_number (sample_number),
    .chunk_number  (chunk_number),
    .status        (status)
  );

endmodule
`default_nettype wire

/* hw/rtl/stco_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stco_cfg
// APB register file: rule_count and chunk_count, saturated for the mapper.
// ----------------------------------------------------------------------------
module stco_cfg
  import stco_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [8:0]  rule_count;
  logic [12:0] chunk_count;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count  <= '0;
      chunk_count <= '0;
    end else if (wr) begin
      if (paddr[2] == REG_RULE_COUNT) begin
        rule_count <= pwdata[8:0];
      end else begin
        chunk_count <= pwdata[12:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_RULE_COUNT) begin
      prdata = {23'd0, rule_count};
    end else begin
      prdata = {19'd0, chunk_count};
    end
  end

  always_comb begin
    cfg.rules_used  = (32'(rule_count) > 32'(MAX_RULES)) ? RULE_CW'(MAX_RULES)
                                                         : RULE_CW'(rule_count);
    cfg.chunks_used = (32'(chunk_count) > 32'(MAX_CHUNKS)) ? CHUNK_CW'(MAX_CHUNKS)
                                                           : CHUNK_CW'(chunk_count);
    cfg.rule_wr     = wr && (paddr[2] == REG_RULE_COUNT);
    cfg.chunk_wr    = wr && (paddr[2] == REG_CHUNK_COUNT);
  end

endmodule
`default_nettype wire

/* hw/rtl/stco_map_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stco_map_ctrl
// Rule and chunk-offset memories with the sequencer that walks them.
// ----------------------------------------------------------------------------
module stco_map_ctrl
  import stco_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [11:0] table_index,
  input  wire logic [31:0] start_chunk,
  input  wire logic [31:0] chunk_sample_count,
  input  wire logic [63:0] chunk_offset,
  input  wire logic [31:0] size_bytes,
  input  wire cfg_t        cfg,
  input  wire logic        out_free,
  output res_t             res
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MAP  = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_RULE = 6'b001000,
    ST_OFS  = 6'b010000,
    ST_FAIL = 6'b100000
  } state_t;

  state_t state;

  // rule word: first chunk in the upper half, samples per chunk in the lower
  logic [63:0] rule_mem  [MAX_RULES];
  logic [63:0] chunk_mem [MAX_CHUNKS];
  logic [63:0] rule_rd_q;
  logic [63:0] chunk_rd_q;

  logic [CHUNK_AW-1:0] cur_chunk;
  logic                chunk_open;
  logic [31:0]         samples_left;
  logic [63:0]         running_offset;
  logic [31:0]         samples_mapped;
  logic [CHUNK_CW-1:0] cand;
  // ptr: how many leading rules have first chunk <= the last tested number;
  // spc_reg holds samples of rule ptr-1
  logic [RULE_CW-1:0]  ptr;
  logic [31:0]         spc_reg;
  logic [31:0]         size_q;

  logic        accept;
  logic        rule_we;
  logic        chunk_we;
  logic        in_range;
  logic        rules_empty;
  logic        rule_rd_en;
  logic        chunk_rd_en;
  logic [32:0] number;
  logic        hit;
  logic [31:0] spc_stop;

  always_comb begin
    in_stall    = (state != ST_IDLE);
    accept      = in_valid && (state == ST_IDLE);
    rule_we     = accept && (action == ACT_LOAD_RULE) &&
                  (32'(table_index) < 32'(MAX_RULES));
    chunk_we    = accept && (action == ACT_LOAD_CHUNK) &&
                  (32'(table_index) < 32'(MAX_CHUNKS));
    in_range    = (cand < cfg.chunks_used);
    rules_empty = (cfg.rules_used == '0);
    number      = 33'(cand) + 33'd1;
    hit         = (33'(rule_rd_q[63:32]) <= number);
    // stopping on rule 0 falls back to rule 0 itself
    spc_stop    = (ptr == '0) ? rule_rd_q[31:0] : spc_reg;
    rule_rd_en  = (state == ST_SCAN) && in_range && !rules_empty &&
                  (ptr != cfg.rules_used);
    chunk_rd_en = ((state == ST_SCAN) && in_range && !rules_empty &&
                   (ptr == cfg.rules_used) && (spc_reg != '0)) ||
                  ((state == ST_RULE) && !hit && (spc_stop != '0));
  end

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[RULE_AW'(table_index)] <= {start_chunk, chunk_sample_count};
    end
    if (rule_rd_en) begin
      rule_rd_q <= rule_mem[ptr[RULE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (chunk_we) begin
      chunk_mem[CHUNK_AW'(table_index)] <= chunk_offset;
    end
    if (chunk_rd_en) begin
      chunk_rd_q <= chunk_mem[cand[CHUNK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cur_chunk      <= '0;
      chunk_open     <= 1'b0;
      samples_left   <= '0;
      running_offset <= '0;
      samples_mapped <= '0;
      ptr            <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (action)
              ACT_LOAD_RULE: begin
                if (rule_we) ptr <= '0;
              end
              ACT_RESTART: begin
                cur_chunk      <= '0;
                chunk_open     <= 1'b0;
                samples_left   <= '0;
                running_offset <= '0;
                samples_mapped <= '0;
                ptr            <= '0;
              end
              ACT_MAP_SAMPLE: begin
                size_q <= size_bytes;
                state  <= ST_MAP;
              end
              default: ;
            endcase
          end
        end
        ST_MAP: begin
          if (samples_left != '0) begin
            if (out_free) begin
              running_offset <= running_offset + 64'(size_q);
              samples_left   <= samples_left - 32'd1;
              samples_mapped <= samples_mapped + 32'd1;
              state          <= ST_IDLE;
            end
          end else begin
            cand  <= chunk_open ? CHUNK_CW'(cur_chunk) + CHUNK_CW'(1) : '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!in_range) begin
            // later searches restart from a lower number
            ptr   <= '0;
            state <= ST_FAIL;
          end else if (rules_empty) begin
            cand <= cand + CHUNK_CW'(1);
          end else if (ptr != cfg.rules_used) begin
            state <= ST_RULE;
          end else if (spc_reg != '0) begin
            samples_left <= spc_reg;
            state        <= ST_OFS;
          end else begin
            cand <= cand + CHUNK_CW'(1);
          end
        end
        ST_RULE: begin
          if (hit) begin
            ptr     <= ptr + RULE_CW'(1);
            spc_reg <= rule_rd_q[31:0];
            state   <= ST_SCAN;
          end else if (spc_stop != '0) begin
            samples_left <= spc_stop;
            state        <= ST_OFS;
          end else begin
            cand  <= cand + CHUNK_CW'(1);
            state <= ST_SCAN;
          end
        end
        ST_OFS: begin
          running_offset <= chunk_rd_q;
          cur_chunk      <= cand[CHUNK_AW-1:0];
          chunk_open     <= 1'b1;
          state          <= ST_MAP;
        end
        ST_FAIL: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      // a changed rule table or chunk limit drops the cached rule position
      if (cfg.rule_wr || cfg.chunk_wr) ptr <= '0;
    end
  end

  always_comb begin
    res.load          = out_free && (((state == ST_MAP) && (samples_left != '0)) ||
                                     (state == ST_FAIL));
    res.sample_number = samples_mapped;
    if (state == ST_FAIL) begin
      res.sample_offset = '0;
      res.chunk_number  = '0;
      res.status        = STATUS_PAST_END;
    end else begin
      res.sample_offset = running_offset;
      res.chunk_number  = 12'(cur_chunk);
      res.status        = STATUS_MAPPED;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/stco_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stco_out_reg
// Output register holding one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module stco_out_reg
  import stco_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire res_t        res,
  output logic             out_free,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] sample_offset,
  output logic      [31:0] sample_number,
  output logic      [11:0] chunk_number,
  output logic             status
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      sample_offset <= res.sample_offset;
      sample_number <= res.sample_number;
      chunk_number  <= res.chunk_number;
      status        <= res.status;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/stco_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stco_checker
// Port-level checks of the mapper, bound to the top level.
// ----------------------------------------------------------------------------
module stco_checker
  import stco_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  action,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] sample_offset,
  input wire logic [31:0] sample_number,
  input wire logic [11:0] chunk_number,
  input wire logic        status
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_offset) &&
      $stable(sample_number) && $stable(chunk_number) && $stable(status))
    else $error("stalled result word changed");

  // past end reports zero offset and chunk
  a_past_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_PAST_END) |->
      (sample_offset == 64'd0) && (chunk_number == 12'd0))
    else $error("past-end word with nonzero offset or chunk");

  // a map keeps the input side busy until its result is produced
  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACT_MAP_SAMPLE) |=> in_stall)
    else $error("input accepted right behind a map");

  // loads and restart make no result word
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action != ACT_MAP_SAMPLE) && !out_valid |=> !out_valid)
    else $error("result word from a non-map action");

endmodule

bind sample_to_chunk_offset_mapper_unit stco_checker u_stco_checker (.*);
`default_nettype wire
